// ===== hdl/aicp_pkg.sv =====
// ----------------------------------------------------------------------------
// aicp_pkg
// Shared types and constants of the ascii integer command parser.
// ----------------------------------------------------------------------------
package aicp_pkg;

  // token scanner phases
  typedef enum logic [1:0] {
    PH_GAP    = 2'd0,
    PH_LEAD   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  localparam int OUT_BITS = 16;

  // mode codes
  localparam int MODE_SWEEP    = 1;
  localparam int MODE_AIM_A    = 2;
  localparam int MODE_AIM_B    = 3;

endpackage

// ===== hdl/aicp_if.sv =====
// ----------------------------------------------------------------------------
// aicp channel interfaces
// Valid/ready channels for received bytes and for applied register items.
// ----------------------------------------------------------------------------
interface aicp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface aicp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [aicp_pkg::OUT_BITS-1:0] mode;
  logic signed [aicp_pkg::OUT_BITS-1:0] min_angle;
  logic signed [aicp_pkg::OUT_BITS-1:0] max_angle;
  logic signed [aicp_pkg::OUT_BITS-1:0] angle_step;
  logic signed [aicp_pkg::OUT_BITS-1:0] aim_angle;

  modport source (output valid, output mode, output min_angle, output max_angle,
                  output angle_step, output aim_angle, input ready);
  modport sink   (input valid, input mode, input min_angle, input max_angle,
                  input angle_step, input aim_angle, output ready);
endinterface

// ===== hdl/ascii_integer_command_parser_top.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_command_parser_top
// Parses "$f0 f1 f2 f3;" frames of ascii integers and applies them as
// mode and angle registers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received byte per item. '$' opens a frame, spaces split
//   tokens, every ';' closes the frame and yields one item on out_ch holding
//   all five applied registers (mode, min/max/step angles, aim angle).
//   Other bytes produce no item.
// Timing:
//   a byte is registered in the input register when accepted and is processed
//   from there; a ';' loads the applied registers and raises the result valid
//   flag, unless an earlier result still waits untaken on out_ch.
//   One byte is taken per cycle unless a ';' waits for the result slot; the scanner
//   updates its token state once per byte, between the input register and the result register.
// Reset:
//   rst_n low clears frame and token state, the field store and the applied
//   registers to zero.
// Stall:
//   while a result waits on out_ch, bytes other than ';' keep flowing;
//   a following ';' waits in the input register until the result is taken.
// ----------------------------------------------------------------------------
module ascii_integer_command_parser_top #(
  parameter int MAX_FIELDS = 4,
  parameter int VALUE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  aicp_in_if.sink         in_ch,
  aicp_out_if.source      out_ch
);

  localparam int FCW   = $clog2(MAX_FIELDS + 1);
  localparam int IW    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int EFF_N = (MAX_FIELDS > 4) ? MAX_FIELDS : 4;
  localparam int XW    = (VALUE_BITS > aicp_pkg::OUT_BITS) ? VALUE_BITS : aicp_pkg::OUT_BITS;

  // input register
  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;

  // scanner state
  logic                  in_frame_r, in_frame_nxt;
  aicp_pkg::phase_t      phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [FCW-1:0]        fc_r, fc_nxt;
  logic [VALUE_BITS-1:0] store_r [MAX_FIELDS];

  // applied registers double as the result payload
  logic [VALUE_BITS-1:0] app_r [5];
  logic [VALUE_BITS-1:0] app_nxt [5];
  logic                  out_valid_r;

  logic                  is_dollar, is_semi, is_space, is_digit, is_blank;
  logic                  proc, do_commit, commit_wr, load_res;
  logic [VALUE_BITS-1:0] digit_val, commit_val;
  logic [VALUE_BITS-1:0] eff [EFF_N];

  assign is_dollar = (s1_byte_r == aicp_pkg::CH_DOLLAR);
  assign is_semi   = (s1_byte_r == aicp_pkg::CH_SEMI);
  assign is_space  = (s1_byte_r == aicp_pkg::CH_SPACE);
  assign is_digit  = (s1_byte_r inside {[aicp_pkg::CH_ZERO:aicp_pkg::CH_NINE]});
  assign is_blank  = (s1_byte_r inside {[aicp_pkg::CH_TAB:aicp_pkg::CH_CR]});
  assign digit_val = VALUE_BITS'(s1_byte_r - aicp_pkg::CH_ZERO);

  // a ';' may only move on when the result slot is free
  assign proc         = s1_valid_r && (!is_semi || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || proc;
  assign load_res     = proc && is_semi;

  assign commit_val = neg_r ? (VALUE_BITS'(0) - acc_r) : acc_r;
  assign commit_wr  = do_commit && (fc_r < FCW'(MAX_FIELDS));

  always_comb begin
    in_frame_nxt = in_frame_r;
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    acc_nxt      = acc_r;
    fc_nxt       = fc_r;
    do_commit    = 1'b0;
    if (proc) begin
      if (is_dollar) begin
        in_frame_nxt = 1'b1;
      end else if (is_semi) begin
        do_commit    = in_frame_r && (phase_r != aicp_pkg::PH_GAP);
        in_frame_nxt = 1'b0;
        phase_nxt    = aicp_pkg::PH_GAP;
        neg_nxt      = 1'b0;
        acc_nxt      = '0;
        fc_nxt       = '0;
      end else if (in_frame_r) begin
        if (is_space) begin
          if (phase_r != aicp_pkg::PH_GAP) begin
            do_commit = 1'b1;
            phase_nxt = aicp_pkg::PH_GAP;
            neg_nxt   = 1'b0;
            acc_nxt   = '0;
            if (fc_r < FCW'(MAX_FIELDS)) begin
              fc_nxt = fc_r + FCW'(1);
            end
          end
        end else begin
          case (phase_r)
            aicp_pkg::PH_GAP, aicp_pkg::PH_LEAD: begin
              if (is_blank || s1_byte_r == aicp_pkg::CH_SPACE) begin
                phase_nxt = aicp_pkg::PH_LEAD;
              end else if (s1_byte_r == aicp_pkg::CH_PLUS) begin
                phase_nxt = aicp_pkg::PH_DIGITS;
              end else if (s1_byte_r == aicp_pkg::CH_MINUS) begin
                neg_nxt   = 1'b1;
                phase_nxt = aicp_pkg::PH_DIGITS;
              end else if (is_digit) begin
                acc_nxt   = digit_val;
                phase_nxt = aicp_pkg::PH_DIGITS;
              end else begin
                phase_nxt = aicp_pkg::PH_DONE;
              end
            end
            aicp_pkg::PH_DIGITS: begin
              if (is_digit) begin
                acc_nxt = (acc_r << 3) + (acc_r << 1) + digit_val;
              end else begin
                phase_nxt = aicp_pkg::PH_DONE;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  // field view seen by the closing ';', including a token committed by it
  always_comb begin
    for (int k = 0; k < EFF_N; k++) begin
      eff[k] = '0;
    end
    for (int k = 0; k < MAX_FIELDS; k++) begin
      eff[k] = (commit_wr && fc_r == FCW'(k)) ? commit_val : store_r[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      app_nxt[k] = app_r[k];
    end
    app_nxt[0] = eff[0];
    if (eff[0] == VALUE_BITS'(aicp_pkg::MODE_SWEEP)) begin
      app_nxt[1] = eff[1];
      app_nxt[2] = eff[2];
      app_nxt[3] = eff[3];
    end else if (eff[0] == VALUE_BITS'(aicp_pkg::MODE_AIM_A) ||
                 eff[0] == VALUE_BITS'(aicp_pkg::MODE_AIM_B)) begin
      app_nxt[4] = eff[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      phase_r    <= aicp_pkg::PH_GAP;
      neg_r      <= 1'b0;
      acc_r      <= '0;
      fc_r       <= '0;
      for (int k = 0; k < MAX_FIELDS; k++) begin
        store_r[k] <= '0;
      end
      for (int k = 0; k < 5; k++) begin
        app_r[k] <= '0;
      end
    end else begin
      in_frame_r <= in_frame_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      acc_r      <= acc_nxt;
      fc_r       <= fc_nxt;
      if (proc && commit_wr) begin
        store_r[fc_r[IW-1:0]] <= commit_val;
      end
      if (load_res) begin
        for (int k = 0; k < 5; k++) begin
          app_r[k] <= app_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.mode       = aicp_pkg::OUT_BITS'(XW'(app_r[0]));
  assign out_ch.min_angle  = aicp_pkg::OUT_BITS'(XW'(app_r[1]));
  assign out_ch.max_angle  = aicp_pkg::OUT_BITS'(XW'(app_r[2]));
  assign out_ch.angle_step = aicp_pkg::OUT_BITS'(XW'(app_r[3]));
  assign out_ch.aim_angle  = aicp_pkg::OUT_BITS'(XW'(app_r[4]));

endmodule

// ===== tb/aicp_result_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_result_check
// Watches both channels of the command parser, tracks frames and tokens from
// every accepted byte, and compares each accepted result item with the
// applied registers it should carry.
// ----------------------------------------------------------------------------
module aicp_result_check (
  input  logic clk,
  input  logic rst_n,
  aicp_in_if   in_ch,
  aicp_out_if  out_ch,
  output int   fail_count,
  output int   pending_results
);

  localparam int FIELDS = 4;

  typedef struct packed {
    logic [15:0] mode;
    logic [15:0] min_angle;
    logic [15:0] max_angle;
    logic [15:0] angle_step;
    logic [15:0] aim_angle;
  } cmd_regs_t;

  logic             frame_open;
  aicp_pkg::phase_t scan_phase;
  logic             token_neg;
  logic [15:0]      token_acc;
  int               field_cnt;
  logic [15:0]      field_vals [FIELDS];
  cmd_regs_t        applied_regs;
  cmd_regs_t        expected_cmds [$];
  cmd_regs_t        want;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0d expected %0d", name, $signed(got),
                                $signed(exp_val)));
  endtask

  task automatic clear_token();
    scan_phase = aicp_pkg::PH_GAP;
    token_neg  = 1'b0;
    token_acc  = '0;
  endtask

  task automatic store_token();
    logic [15:0] v;
    v = token_neg ? -token_acc : token_acc;
    if (field_cnt < FIELDS) begin
      field_vals[field_cnt] = v;
      field_cnt++;
    end
    clear_token();
  endtask

  // advance the parser by one byte; a ';' queues the registers it applies
  task automatic take_byte(input logic [7:0] b);
    logic digit;
    logic blank;
    digit = (b >= aicp_pkg::CH_ZERO) && (b <= aicp_pkg::CH_NINE);
    blank = (b >= aicp_pkg::CH_TAB) && (b <= aicp_pkg::CH_CR);
    if (b == aicp_pkg::CH_DOLLAR) begin
      frame_open = 1'b1;
    end else if (b == aicp_pkg::CH_SEMI) begin
      if (frame_open && scan_phase != aicp_pkg::PH_GAP) store_token();
      frame_open = 1'b0;
      clear_token();
      field_cnt = 0;
      applied_regs.mode = field_vals[0];
      if (field_vals[0] == 16'(aicp_pkg::MODE_SWEEP)) begin
        applied_regs.min_angle  = field_vals[1];
        applied_regs.max_angle  = field_vals[2];
        applied_regs.angle_step = field_vals[3];
      end else if (field_vals[0] == 16'(aicp_pkg::MODE_AIM_A) ||
                   field_vals[0] == 16'(aicp_pkg::MODE_AIM_B)) begin
        applied_regs.aim_angle = field_vals[1];
      end
      expected_cmds.push_back(applied_regs);
    end else if (frame_open) begin
      if (b == aicp_pkg::CH_SPACE) begin
        if (scan_phase != aicp_pkg::PH_GAP) store_token();
      end else begin
        case (scan_phase)
          aicp_pkg::PH_GAP, aicp_pkg::PH_LEAD: begin
            if (blank) begin
              scan_phase = aicp_pkg::PH_LEAD;
            end else if (b == aicp_pkg::CH_PLUS) begin
              scan_phase = aicp_pkg::PH_DIGITS;
            end else if (b == aicp_pkg::CH_MINUS) begin
              token_neg  = 1'b1;
              scan_phase = aicp_pkg::PH_DIGITS;
            end else if (digit) begin
              token_acc  = 16'(b - aicp_pkg::CH_ZERO);
              scan_phase = aicp_pkg::PH_DIGITS;
            end else begin
              scan_phase = aicp_pkg::PH_DONE;
            end
          end
          aicp_pkg::PH_DIGITS: begin
            if (digit) token_acc = token_acc * 16'd10 + 16'(b - aicp_pkg::CH_ZERO);
            else scan_phase = aicp_pkg::PH_DONE;
          end
          default: ;
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_open   = 1'b0;
      field_cnt    = 0;
      applied_regs = '0;
      fail_count   = 0;
      clear_token();
      for (int i = 0; i < FIELDS; i++) field_vals[i] = '0;
      expected_cmds.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) take_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("result item with no command pending");
        end else begin
          want = expected_cmds.pop_front();
          check_field("mode", out_ch.mode, want.mode);
          check_field("min_angle", out_ch.min_angle, want.min_angle);
          check_field("max_angle", out_ch.max_angle, want.max_angle);
          check_field("angle_step", out_ch.angle_step, want.angle_step);
          check_field("aim_angle", out_ch.aim_angle, want.aim_angle);
        end
      end
    end
    pending_results <= expected_cmds.size();
  end

endmodule

// ===== tb/ascii_integer_command_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_command_parser_top_tb
// Feeds the command parser directed frames and then random frames, noise and
// broken frames, with sender gaps and receiver stalls in several phases; the
// result checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module ascii_integer_command_parser_top_tb;

  localparam int BYTES_PER_PHASE = 175;

  logic clk;
  logic rst_n;
  logic sink_ready = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   sent_bytes = 0;
  int   fail_count;
  int   pending_results;

  aicp_in_if  in_ch ();
  aicp_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  ascii_integer_command_parser_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  aicp_result_check result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    sink_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // valid stays high from one item to the next unless a gap is drawn
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic send_token(input bit is_mode);
    string num;
    int    sel;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) send_byte(aicp_pkg::CH_TAB + 8'($urandom_range(0, 4)));
    if (is_mode) begin
      if (sel >= 96) send_byte(aicp_pkg::CH_MINUS);
      if (sel < 85) num = $sformatf("%0d", $urandom_range(0, 3));
      else num = $sformatf("%0d", $urandom);
    end else begin
      if (sel < 20) send_byte(aicp_pkg::CH_MINUS);
      else if (sel < 30) send_byte(aicp_pkg::CH_PLUS);
      if (sel % 10 < 6) num = $sformatf("%0d", $urandom_range(0, 360));
      else if (sel % 10 < 9) num = $sformatf("%0d", $urandom_range(0, 65535));
      else num = $sformatf("%0d", $urandom);
    end
    // sign with no digits, or a token cut short by a stray byte
    if ($urandom_range(0, 19) == 0) num = "";
    send_text(num);
    if ($urandom_range(0, 14) == 0) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame();
    int n_tok;
    n_tok = $urandom_range(0, 6);
    send_byte(aicp_pkg::CH_DOLLAR);
    for (int t = 0; t < n_tok; t++) begin
      if (t > 0) begin
        send_byte(aicp_pkg::CH_SPACE);
        if ($urandom_range(0, 9) == 0) send_byte(aicp_pkg::CH_SPACE);
      end
      if ($urandom_range(0, 19) == 0) send_byte(aicp_pkg::CH_DOLLAR);
      send_token(t == 0);
    end
    if ($urandom_range(0, 9) == 0) send_byte(aicp_pkg::CH_SPACE);
    // now and then the frame is left open and runs into the next one
    if ($urandom_range(0, 9) != 0) send_byte(aicp_pkg::CH_SEMI);
  endtask

  initial begin
    int phase_end;
    int pick;
    rst_n = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: close outside a frame, ignored byte, empty frame, sweep with
    // signs, junk token, dollar inside a frame, wrap and a dropped field, then
    // leading blank, plus sign and nul terminator, then the largest value
    send_byte(aicp_pkg::CH_SEMI);
    send_byte(8'hff);
    send_text("$;");
    send_text("$1 -7 x9 $70000 5;");
    send_byte(aicp_pkg::CH_DOLLAR);
    send_byte(aicp_pkg::CH_TAB);
    send_text("2 +3");
    send_byte(8'h00);
    send_byte(aicp_pkg::CH_SEMI);
    send_text("$3 65535;");

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
        1: begin send_idle_pct <= 59; stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  stall_pct <= 59; end
        default: begin send_idle_pct <= 21; stall_pct <= 21; end
      endcase
      phase_end = sent_bytes + BYTES_PER_PHASE;
      while (sent_bytes < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_frame();
        end else if (pick < 92) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 96) begin
          send_byte(aicp_pkg::CH_SEMI);
        end else begin
          send_byte(aicp_pkg::CH_DOLLAR);
        end
      end
    end
    send_byte(aicp_pkg::CH_SEMI);
    in_ch.valid <= 1'b0;

    // the count seen here is registered in the checker, so it lags the checker's queue
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", pending_results);
    $display("== FAIL ==");
    $finish;
  end

endmodule
